// ===== hw/rtl/tbwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwc_pkg
// Shared types and codes for the time bucket window counter.
// ----------------------------------------------------------------------------
package tbwc_pkg;

  localparam int TIME_W = 64;
  localparam int REG_W  = 40;
  localparam int DEV_W  = 8;
  localparam int VAL_W  = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_BAD_ID = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_DURATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 1'b1;

  localparam logic [REG_W-1:0] BUCKET_DURATION_RST = 40'd100000000;
  localparam logic [REG_W-1:0] WINDOW_LENGTH_RST   = 40'd1000000000;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] dim_sum;
    logic [TIME_W-1:0] launches;
  } bucket_t;

endpackage

// ===== hw/rtl/tbwc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwc_div
// Bit-serial restoring divider: remainder of a 64-bit time by the bucket
// duration, and the quotient modulo the ring size, one bit per cycle.
// ----------------------------------------------------------------------------
module tbwc_div #(
  parameter int BUCKET_COUNT = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [tbwc_pkg::TIME_W-1:0]        dividend,
  input  logic [tbwc_pkg::REG_W-1:0]         divisor,
  output logic                               done,
  output logic [tbwc_pkg::REG_W-1:0]         remainder,
  output logic [$clog2(BUCKET_COUNT)-1:0]    slot
);
  import tbwc_pkg::*;

  localparam int SW = $clog2(BUCKET_COUNT);
  localparam int CW = $clog2(TIME_W);

  logic [TIME_W-1:0] dvd_r;
  logic [REG_W-1:0]  rem_r;
  logic [SW-1:0]     slot_r;
  logic [CW-1:0]     cnt_r;
  logic              run_r;
  logic              done_r;

  logic [REG_W:0]    rem_sh;
  logic              ge;
  logic [REG_W-1:0]  rem_nxt;
  logic [SW:0]       slot_sh;
  logic [SW-1:0]     slot_nxt;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[TIME_W-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_nxt = ge ? REG_W'(rem_sh - {1'b0, divisor}) : rem_sh[REG_W-1:0];
    slot_sh = {slot_r, ge};
    if (slot_sh >= (SW+1)'(BUCKET_COUNT)) begin
      slot_nxt = SW'(slot_sh - (SW+1)'(BUCKET_COUNT));
    end else begin
      slot_nxt = slot_sh[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && run_r && (cnt_r == CW'(TIME_W-1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(TIME_W-1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      rem_r  <= '0;
      slot_r <= '0;
    end else if (run_r) begin
      dvd_r  <= {dvd_r[TIME_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      slot_r <= slot_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;
  assign slot      = slot_r;

endmodule

// ===== hw/rtl/tbwc_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwc_mem
// Bucket store: one entry per device and ring slot, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module tbwc_mem #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  tbwc_pkg::bucket_t        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output tbwc_pkg::bucket_t        rd_data
);
  import tbwc_pkg::*;

  bucket_t mem_r [DEPTH];
  bucket_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/time_bucket_window_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_bucket_window_counter_unit
// Per-device ring of time buckets: records launches into the current bucket
// and returns windowed sums of block dimension and launch count.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  op, device_id, now_time, blk_size,
//                                        launch_amount
// out      output     out_valid/out_stall status, dim_total, launch_total
// cfg      input      cfg_wr_en          cfg_index, cfg_wdata
//
// Record: the 64-step serial divider, then one read and one write of the
// bucket store. Query: one store read per bucket. Bad device id: goes
// straight to the result.
// After reset every entry of the store is cleared with in_stall high. One
// request at a time; the next one is taken while a result waits in the
// output register.
// ----------------------------------------------------------------------------
module time_bucket_window_counter_unit #(
  parameter int DEVICE_COUNT = 16,
  parameter int BUCKET_COUNT = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [tbwc_pkg::DEV_W-1:0]         in_device_id,
  input  logic [tbwc_pkg::TIME_W-1:0]        in_now_time,
  input  logic [tbwc_pkg::VAL_W-1:0]         in_blk_size,
  input  logic [tbwc_pkg::VAL_W-1:0]         in_launch_amount,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_status,
  output logic [tbwc_pkg::TIME_W-1:0]        out_dim_total,
  output logic [tbwc_pkg::TIME_W-1:0]        out_launch_total,
  input  logic                               cfg_wr_en,
  input  logic [tbwc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tbwc_pkg::REG_W-1:0]         cfg_wdata
);
  import tbwc_pkg::*;

  localparam int NUM = DEVICE_COUNT * BUCKET_COUNT;
  localparam int AW  = $clog2(NUM);
  localparam int SW  = $clog2(BUCKET_COUNT);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_WR    = 4'd4;
  localparam logic [3:0] ST_QPREP = 4'd5;
  localparam logic [3:0] ST_QWALK = 4'd6;
  localparam logic [3:0] ST_FIN   = 4'd7;

  logic [3:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r;
  logic [REG_W-1:0]  dur_r, win_r;
  logic [REG_W-1:0]  dur_eff;

  logic [DEV_W-1:0]  dev_r;
  logic [TIME_W-1:0] now_r;
  logic [VAL_W-1:0]  dim_r, amt_r;
  logic              status_r;
  logic [TIME_W-1:0] start_r, lo_r;
  logic [AW-1:0]     addr_r;

  logic [SW-1:0]     q_idx_r;
  logic              q_issue_r;
  logic              rv_r, rl_r, hv_r, hl_r, hit_r;
  logic [TIME_W-1:0] hd_r, hc_r;
  logic [TIME_W-1:0] acc_dim_r, acc_cnt_r;

  logic              out_valid_r, out_status_r;
  logic [TIME_W-1:0] out_dim_r, out_cnt_r;

  logic              in_take, dev_ok, div_start, div_done, out_load;
  logic [REG_W-1:0]  div_rem;
  logic [SW-1:0]     div_slot;
  logic [AW-1:0]     q_addr;

  logic              mem_wr_en, mem_rd_en;
  logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
  bucket_t           mem_wr_data, mem_rd_data;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign dev_ok    = 32'(in_device_id) < DEVICE_COUNT;
  assign div_start = in_take && dev_ok && (in_op == OP_RECORD);
  assign dur_eff   = (dur_r == '0) ? REG_W'(1) : dur_r;
  assign q_addr    = AW'(32'(dev_r) * 32'(BUCKET_COUNT) + 32'(q_idx_r));
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  tbwc_div #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_now_time),
    .divisor  (dur_eff),
    .done     (div_done),
    .remainder(div_rem),
    .slot     (div_slot)
  );

  tbwc_mem #(
    .DEPTH(NUM)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = addr_r;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = addr_r;
    case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr_r;
      end
      ST_RD: begin
        mem_rd_en = 1'b1;
      end
      ST_WR: begin
        mem_wr_en = 1'b1;
        mem_wr_data.start = start_r;
        if (mem_rd_data.start != start_r) begin
          mem_wr_data.dim_sum  = TIME_W'(dim_r);
          mem_wr_data.launches = TIME_W'(amt_r);
        end else begin
          mem_wr_data.dim_sum  = mem_rd_data.dim_sum + TIME_W'(dim_r);
          mem_wr_data.launches = mem_rd_data.launches + TIME_W'(amt_r);
        end
      end
      ST_QWALK: begin
        mem_rd_en   = q_issue_r;
        mem_rd_addr = q_addr;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == AW'(NUM-1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_take) begin
          if (!dev_ok) state_nxt = ST_FIN;
          else if (in_op == OP_RECORD) state_nxt = ST_DIV;
          else state_nxt = ST_QPREP;
        end
      end
      ST_DIV:   if (div_done) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_WR;
      ST_WR:    state_nxt = ST_FIN;
      ST_QPREP: state_nxt = ST_QWALK;
      ST_QWALK: if (hv_r && hl_r) state_nxt = ST_FIN;
      ST_FIN:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      dur_r       <= BUCKET_DURATION_RST;
      win_r       <= WINDOW_LENGTH_RST;
      q_issue_r   <= 1'b0;
      rv_r        <= 1'b0;
      rl_r        <= 1'b0;
      hv_r        <= 1'b0;
      hl_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BUCKET_DURATION: dur_r <= cfg_wdata;
          REG_WINDOW_LENGTH:   win_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (state_r == ST_QPREP) begin
        q_issue_r <= 1'b1;
      end else if (state_r == ST_QWALK && q_idx_r == SW'(BUCKET_COUNT-1)) begin
        q_issue_r <= 1'b0;
      end
      rv_r <= (state_r == ST_QWALK) && q_issue_r;
      rl_r <= (state_r == ST_QWALK) && q_issue_r && (q_idx_r == SW'(BUCKET_COUNT-1));
      hv_r <= rv_r;
      hl_r <= rl_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      dev_r     <= in_device_id;
      now_r     <= in_now_time;
      dim_r     <= in_blk_size;
      amt_r     <= in_launch_amount;
      status_r  <= dev_ok ? STATUS_OK : STATUS_BAD_ID;
      acc_dim_r <= '0;
      acc_cnt_r <= '0;
    end else if (hv_r && hit_r) begin
      acc_dim_r <= acc_dim_r + hd_r;
      acc_cnt_r <= acc_cnt_r + hc_r;
    end
    if (state_r == ST_DIV && div_done) begin
      start_r <= now_r - TIME_W'(div_rem);
      addr_r  <= AW'(32'(dev_r) * 32'(BUCKET_COUNT) + 32'(div_slot));
    end
    if (state_r == ST_QPREP) begin
      lo_r    <= (now_r >= TIME_W'(win_r)) ? now_r - TIME_W'(win_r) : '0;
      q_idx_r <= '0;
    end else if (state_r == ST_QWALK && q_issue_r) begin
      q_idx_r <= q_idx_r + 1'b1;
    end
    hit_r <= (mem_rd_data.start != '0) && (mem_rd_data.start >= lo_r)
             && (mem_rd_data.start <= now_r);
    hd_r  <= mem_rd_data.dim_sum;
    hc_r  <= mem_rd_data.launches;
    if (out_load) begin
      out_status_r <= status_r;
      out_dim_r    <= acc_dim_r;
      out_cnt_r    <= acc_cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_dim_total    = out_dim_r;
  assign out_launch_total = out_cnt_r;

endmodule
